[rtl/kvba_pkg.sv]
// kvba_pkg: shared constants, codes and beat types of the KV cache block allocator.
// No dependencies; used by kvba_if.sv and kv_cache_block_allocator.sv.
package kvba_pkg;

  localparam int POOL_BLOCKS  = 256;
  localparam int MAX_REQUESTS = 16;
  localparam int MAX_BPR      = 64;

  localparam int FUNC_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int TOK_W   = 14;
  localparam int STAT_W  = 3;
  localparam int BLK_W   = 8;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam int BS_MAX  = 256;
  localparam int BIN_MAX = (POOL_BLOCKS < 256) ? POOL_BLOCKS : 256;
  localparam int BS_RST  = 16;

  localparam int SI_W    = $clog2(POOL_BLOCKS);
  localparam int FC_W    = $clog2(POOL_BLOCKS + 1);
  localparam int OC_W    = $clog2(MAX_BPR + 1);
  localparam int OWN_DEPTH = MAX_REQUESTS * MAX_BPR;
  localparam int OWN_AW  = (OWN_DEPTH > 1) ? $clog2(OWN_DEPTH) : 1;
  localparam int SUM_W   = TOK_W + 1;
  localparam int NEED_W  = SUM_W + 1;
  localparam int DCNT_W  = $clog2(SUM_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_LIST    = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOFREE = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BAD    = 3'd3,
    ST_LIMIT  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE    = 1'd0,
    REG_BLOCKS_IN_USE = 1'd1
  } reg_e;

  typedef struct packed {
    func_e             func;
    logic [SLOT_W-1:0] req_slot;
    logic [TOK_W-1:0]  computed_tokens;
    logic [TOK_W-1:0]  scheduled_tokens;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] block_number;
    logic             block_valid;
    logic             last;
  } out_item_t;

  function automatic logic [CFG_W-1:0] sat_cfg(logic [CFG_W-1:0] v, int hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > hi) begin
      r = CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/kvba_if.sv]
// kvba_in_if / kvba_out_if: valid/ready channels for request and result beats.
// Depends on kvba_pkg for the beat types.
interface kvba_in_if;
  import kvba_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kvba_out_if;
  import kvba_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/kv_cache_block_allocator.sv]
// kv_cache_block_allocator: paged KV cache block allocator, free stack and owned lists in RAM.
// Depends on kvba_pkg and the channel interfaces in kvba_if.sv.
//
//   channel  dir  handshake           beat
//   in_i     in   valid/ready         func, req_slot, computed_tokens, scheduled_tokens
//   out_o    out  valid/ready         status, block_number, block_valid, last
//   cfg      in   cfg_we_i (no wait)  cfg_idx_i, cfg_data_i
//
// One request at a time. Allocate runs the divider, a check state, the block copy and a result
// beat. Release returns owned blocks then sends a result; List sends one beat per owned block.
// Copies run at one entry per cycle, set by the single read and write port of each RAM.
// Reset and every config write rebuild the free stack at once through per-entry valid bits.
// A stalled output holds one beat; the next request is taken while it waits.
module kv_cache_block_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  kvba_in_if.sink                        in_i,
  kvba_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [kvba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kvba_pkg::CFG_W-1:0]     cfg_data_i
);
  import kvba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CHECK, S_ALLOC, S_REL, S_LIST, S_DONE
  } state_e;

  state_e                       state_q;
  logic [CFG_W-1:0]             bs_q, bin_q;
  logic [FC_W-1:0]              free_cnt_q;
  logic [POOL_BLOCKS-1:0]       stk_vld_q;
  logic [OC_W-1:0]              own_cnt_q [MAX_REQUESTS];
  logic [SLOT_W-1:0]            slot_q;
  logic [OC_W-1:0]              have_q, need_q, take_q, cnt_q, ofs_q;
  logic [FC_W-1:0]              first_q;
  logic                         pend_q;
  status_e                      st_q;
  logic [CFG_W-1:0]             rem_q;
  logic [SUM_W-1:0]             dvd_q, quo_q;
  logic [DCNT_W-1:0]            dcnt_q;
  logic                         out_valid_q;
  out_item_t                    out_q;

  logic [BLK_W-1:0]             stk_mem [POOL_BLOCKS];
  logic [BLK_W-1:0]             stk_rdata_q;
  logic [SI_W-1:0]              stk_ridx_q;
  logic                         stk_hit_q;
  logic [BLK_W-1:0]             own_mem [OWN_DEPTH];
  logic [BLK_W-1:0]             own_rdata_q;

  logic                         in_acc, out_free, list_load, out_load;
  logic                         stk_re, own_re, own_we, stk_we;
  logic [SI_W-1:0]              stk_raddr, stk_waddr;
  logic [OWN_AW-1:0]            own_raddr, own_waddr;
  logic [BLK_W-1:0]             stk_val;
  logic [OC_W-1:0]              have_in;
  logic                         slot_bad;
  logic [CFG_W:0]               trial;
  logic                         qbit;
  logic [NEED_W-1:0]            need, take;
  logic [CFG_W-1:0]             cfg_sat;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign slot_bad = (int'(in_i.data.req_slot) >= MAX_REQUESTS);
  assign have_in  = slot_bad ? '0 : own_cnt_q[in_i.data.req_slot];

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, bs_q});
  assign need  = NEED_W'(quo_q) + NEED_W'(rem_q != '0);
  assign take  = need - NEED_W'(have_q);

  assign stk_re    = (state_q == S_ALLOC) && (cnt_q < take_q);
  assign stk_raddr = SI_W'(first_q + FC_W'(cnt_q));
  assign stk_val   = stk_hit_q ? stk_rdata_q : BLK_W'(stk_ridx_q);
  assign own_we    = (state_q == S_ALLOC) && pend_q;
  assign own_waddr = OWN_AW'(int'(slot_q) * MAX_BPR + int'(ofs_q));

  assign list_load = (state_q == S_LIST) && pend_q && out_free;
  assign out_load  = list_load || ((state_q == S_DONE) && out_free);
  assign own_re    = ((state_q == S_REL) || ((state_q == S_LIST) && (!pend_q || list_load)))
                     && (cnt_q < have_q);
  assign own_raddr = OWN_AW'(int'(slot_q) * MAX_BPR + int'(cnt_q));
  assign stk_we    = (state_q == S_REL) && pend_q && (int'(free_cnt_q) < POOL_BLOCKS);
  assign stk_waddr = SI_W'(free_cnt_q);

  assign cfg_sat = sat_cfg(cfg_data_i, (cfg_idx_i == REG_BLOCK_SIZE) ? BS_MAX : BIN_MAX);

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= own_rdata_q;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
      stk_hit_q   <= stk_vld_q[stk_raddr];
      stk_ridx_q  <= stk_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_waddr] <= stk_val;
    end
    if (own_re) begin
      own_rdata_q <= own_mem[own_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bs_q        <= CFG_W'(BS_RST);
      bin_q       <= CFG_W'(BIN_MAX);
      free_cnt_q  <= FC_W'(BIN_MAX);
      stk_vld_q   <= '0;
      own_cnt_q   <= '{default: '0};
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      ofs_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            slot_q <= in_i.data.req_slot;
            have_q <= have_in;
            cnt_q  <= '0;
            ofs_q  <= '0;
            pend_q <= 1'b0;
            if (slot_bad) begin
              st_q    <= ST_BAD;
              state_q <= S_DONE;
            end else begin
              unique case (in_i.data.func)
                FUNC_ALLOC: begin
                  if (in_i.data.scheduled_tokens == '0) begin
                    st_q    <= ST_BAD;
                    state_q <= S_DONE;
                  end else begin
                    dvd_q   <= SUM_W'(in_i.data.computed_tokens)
                               + SUM_W'(in_i.data.scheduled_tokens);
                    rem_q   <= '0;
                    quo_q   <= '0;
                    dcnt_q  <= '0;
                    state_q <= S_DIV;
                  end
                end
                FUNC_RELEASE, FUNC_LIST: begin
                  if (have_in == '0) begin
                    st_q    <= ST_EMPTY;
                    state_q <= S_DONE;
                  end else begin
                    state_q <= (in_i.data.func == FUNC_RELEASE) ? S_REL : S_LIST;
                  end
                end
                default: begin
                  st_q    <= ST_BAD;
                  state_q <= S_DONE;
                end
              endcase
            end
          end
        end
        S_DIV: begin
          rem_q  <= qbit ? CFG_W'(trial - {1'b0, bs_q}) : CFG_W'(trial);
          quo_q  <= {quo_q[SUM_W-2:0], qbit};
          dvd_q  <= {dvd_q[SUM_W-2:0], 1'b0};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_q <= S_DONE;
          if (need < NEED_W'(have_q)) begin
            st_q <= ST_BAD;
          end else if (need == NEED_W'(have_q)) begin
            st_q <= ST_OK;
          end else if (need > NEED_W'(MAX_BPR)) begin
            st_q <= ST_LIMIT;
          end else if (take > NEED_W'(free_cnt_q)) begin
            st_q <= ST_NOFREE;
          end else begin
            st_q    <= ST_OK;
            take_q  <= OC_W'(take);
            need_q  <= OC_W'(need);
            first_q <= free_cnt_q - FC_W'(take);
            ofs_q   <= have_q;
            state_q <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          pend_q <= stk_re;
          if (stk_re) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (own_we) begin
            ofs_q <= ofs_q + 1'b1;
          end
          if (!stk_re && !pend_q) begin
            free_cnt_q        <= first_q;
            own_cnt_q[slot_q] <= need_q;
            state_q           <= S_DONE;
          end
        end
        S_REL: begin
          pend_q <= own_re;
          if (own_re) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (stk_we) begin
            stk_vld_q[stk_waddr] <= 1'b1;
            free_cnt_q           <= free_cnt_q + 1'b1;
          end
          if (!own_re && !pend_q) begin
            own_cnt_q[slot_q] <= '0;
            st_q              <= ST_OK;
            state_q           <= S_DONE;
          end
        end
        S_LIST: begin
          if (own_re) begin
            cnt_q  <= cnt_q + 1'b1;
            pend_q <= 1'b1;
          end else if (list_load) begin
            pend_q <= 1'b0;
          end
          if (list_load) begin
            out_valid_q        <= 1'b1;
            out_q.status       <= ST_OK;
            out_q.block_number <= own_rdata_q;
            out_q.block_valid  <= 1'b1;
            out_q.last         <= (ofs_q + 1'b1 == have_q);
            ofs_q              <= ofs_q + 1'b1;
            if (ofs_q + 1'b1 == have_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.status       <= st_q;
            out_q.block_number <= '0;
            out_q.block_valid  <= 1'b0;
            out_q.last         <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLOCK_SIZE: begin
            bs_q       <= cfg_sat;
            free_cnt_q <= FC_W'(bin_q);
          end
          REG_BLOCKS_IN_USE: begin
            bin_q      <= cfg_sat;
            free_cnt_q <= FC_W'(cfg_sat);
          end
          default: ;
        endcase
        stk_vld_q <= '0;
        own_cnt_q <= '{default: '0};
      end
    end
  end

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FC_W'(free_cnt_q) <= FC_W'(bin_q))
    else $error("free count above managed blocks");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("request taken while busy");

  a_list_beat_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.block_valid |-> out_o.data.status == ST_OK)
    else $error("listed block with error status");

endmodule
